// ===== sv/njn_pkg.sv =====
// Shared constants, types and codes of the nested-loop equi-join block.
package njn_pkg;

  localparam int DATA_W         = 32;
  localparam int MAX_INNER_ROWS = 64;
  localparam int MAX_COLUMNS    = 10;
  localparam int ROW_IDX_W      = $clog2(MAX_INNER_ROWS);
  localparam int ROW_CNT_W      = $clog2(MAX_INNER_ROWS + 1);
  localparam int COL_W          = 4;
  localparam int ROW_W          = MAX_COLUMNS * DATA_W;
  localparam int IN_TDATA_W     = ((ROW_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W    = ((ROW_IDX_W + ROW_W + 7) / 8) * 8;
  localparam int CMD_W          = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 4;

  typedef logic [MAX_COLUMNS-1:0][DATA_W-1:0] row_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PROBE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTER_KEY  = 2'd0,
    CFG_INNER_KEY  = 2'd1,
    CFG_INNER_COLS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } scan_state_t;

  typedef struct packed {
    logic                 start;
    logic [DATA_W-1:0]    key;
    logic [ROW_CNT_W-1:0] rows;
    logic [COL_W-1:0]     key_col;
  } scan_req_t;

endpackage

// ===== sv/njn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module njn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/njn_scan.sv =====
// Probe engine: walks stored rows, compares keys, holds one match back to flag the last.
module njn_scan (
  input  logic                                      clk,
  input  logic                                      rst,
  input  njn_pkg::scan_req_t                        req,
  output logic                                      busy,
  output logic                                      rd_en,
  output logic [njn_pkg::ROW_IDX_W-1:0]             rd_addr,
  input  logic [njn_pkg::ROW_W-1:0]                 rd_data,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [njn_pkg::OUT_TDATA_W-1:0]           m_tdata,
  output logic                                      m_tlast
);
  import njn_pkg::*;

  scan_state_t          state, state_next;
  logic [DATA_W-1:0]    key;
  logic [ROW_CNT_W-1:0] rows;
  logic [COL_W-1:0]     key_sel;
  logic [ROW_CNT_W-1:0] issue_idx;
  logic                 dv;
  logic [ROW_IDX_W-1:0] didx;
  logic                 pend_v;
  logic [ROW_IDX_W-1:0] pend_idx;
  logic [ROW_W-1:0]     pend_row;
  logic [ROW_IDX_W-1:0] out_idx;
  logic [ROW_W-1:0]     out_row;
  row_t                 cur_row;
  logic                 match;
  logic                 out_free;
  logic                 stall;
  logic                 push;
  logic                 push_last;

  assign cur_row  = row_t'(rd_data);
  assign match    = dv && (cur_row[key_sel] == key);
  assign out_free = !m_tvalid || m_tready;
  assign busy     = (state != ST_IDLE);
  assign rd_addr  = issue_idx[ROW_IDX_W-1:0];
  assign m_tdata  = {{(OUT_TDATA_W - ROW_W - ROW_IDX_W){1'b0}}, out_row, out_idx};

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    stall      = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req.start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        stall = match && pend_v && !out_free;
        push  = match && pend_v && out_free;
        if (!stall) begin
          if (issue_idx < rows) begin
            rd_en = 1'b1;
          end else if (!dv) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_idx <= '0;
      dv        <= 1'b0;
      pend_v    <= 1'b0;
      m_tvalid  <= 1'b0;
      m_tlast   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && req.start) begin
        issue_idx <= '0;
        dv        <= 1'b0;
        pend_v    <= 1'b0;
      end else if (state == ST_SCAN && !stall) begin
        issue_idx <= issue_idx + ROW_CNT_W'(rd_en);
        dv        <= rd_en;
        if (match) begin
          pend_v <= 1'b1;
        end
      end else if (state == ST_FLUSH && push) begin
        pend_v <= 1'b0;
      end
      if (push) begin
        m_tvalid <= 1'b1;
        m_tlast  <= push_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.start) begin
      key     <= req.key;
      rows    <= req.rows;
      key_sel <= req.key_col - COL_W'(1);
    end
    if (rd_en) begin
      didx <= issue_idx[ROW_IDX_W-1:0];
    end
    if (state == ST_SCAN && !stall && match) begin
      pend_row <= rd_data;
      pend_idx <= didx;
    end
    if (push) begin
      out_row <= pend_row;
      out_idx <= pend_idx;
    end
  end

endmodule

// ===== sv/nested_loop_equi_join_top.sv =====
// Nested-loop equi-join top level: command decode, configuration, row store and probe engine.
//
// Input channel s_*: one item per command. s_tuser carries the command (load inner row,
// probe with outer row, clear table); s_tdata carries the ten 32-bit row columns.
// A load appends a row (unused columns stored as zero, dropped when 64 rows are stored),
// a clear empties the table. A probe walks the stored rows in load order, one row a cycle
// out of the row memory's single read port while no stall holds it, and sends every row
// whose key equals the probe key on m_*: index and columns in m_tdata, m_tlast on the
// last match; no match gives no item. s_tready is low while a probe is in progress. The
// output register lets the next command in while the final result still waits. A stall
// on m_tready holds the walk at the next match. The user writes configuration on
// cfg_we/cfg_addr/cfg_wdata only while the block is idle; the block does not enforce it.
// Reset (rst, synchronous) empties the table, restores key columns 1 and 1 and ten
// inner columns, and drops any result in flight; the row memory itself is not cleared.
module nested_loop_equi_join_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [njn_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [njn_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // value_0 .. value_9, 32 bits each, value_0 lowest
  input  logic [njn_pkg::IN_TDATA_W-1:0]      s_tdata,
  // command
  input  logic [njn_pkg::CMD_W-1:0]           s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // inner_row_index, match_0 .. match_9, zero pad
  output logic [njn_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                m_tlast
);
  import njn_pkg::*;

  logic [COL_W-1:0]     outer_key_column;
  logic [COL_W-1:0]     inner_key_column;
  logic [COL_W-1:0]     inner_columns;
  logic [ROW_CNT_W-1:0] inner_row_count;
  logic [COL_W-1:0]     used_cols;
  logic                 accept;
  logic                 keys_ok;
  logic                 wr_en;
  row_t                 in_row;
  row_t                 wr_row;
  scan_req_t            req;
  logic                 busy;
  logic                 rd_en;
  logic [ROW_IDX_W-1:0] rd_addr;
  logic [ROW_W-1:0]     rd_data;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign in_row   = row_t'(s_tdata[ROW_W-1:0]);
  assign keys_ok  = (outer_key_column >= COL_W'(1)) && (outer_key_column <= COL_W'(MAX_COLUMNS))
                 && (inner_key_column >= COL_W'(1)) && (inner_key_column <= COL_W'(MAX_COLUMNS));

  always_comb begin
    if (inner_columns == '0) begin
      used_cols = COL_W'(1);
    end else if (inner_columns > COL_W'(MAX_COLUMNS)) begin
      used_cols = COL_W'(MAX_COLUMNS);
    end else begin
      used_cols = inner_columns;
    end
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      wr_row[j] = (COL_W'(j) < used_cols) ? in_row[j] : '0;
    end
  end

  assign wr_en = accept && (s_tuser == CMD_LOAD)
              && (inner_row_count < ROW_CNT_W'(MAX_INNER_ROWS));

  always_comb begin
    req.start   = accept && (s_tuser == CMD_PROBE) && keys_ok && (inner_row_count != '0);
    req.key     = in_row[outer_key_column - COL_W'(1)];
    req.rows    = inner_row_count;
    req.key_col = inner_key_column;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_key_column <= COL_W'(1);
      inner_key_column <= COL_W'(1);
      inner_columns    <= COL_W'(MAX_COLUMNS);
      inner_row_count  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_OUTER_KEY:  outer_key_column <= cfg_wdata;
          CFG_INNER_KEY:  inner_key_column <= cfg_wdata;
          CFG_INNER_COLS: inner_columns    <= cfg_wdata;
          default: ;
        endcase
      end
      if (wr_en) begin
        inner_row_count <= inner_row_count + ROW_CNT_W'(1);
      end else if (accept && s_tuser == CMD_CLEAR) begin
        inner_row_count <= '0;
      end
    end
  end

  njn_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_INNER_ROWS)
  ) u_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (inner_row_count[ROW_IDX_W-1:0]),
    .wdata (wr_row),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  njn_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .busy     (busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== sv/njn_checker.sv =====
// Port-level checks of the nested-loop equi-join top level, bound to it.
module njn_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [njn_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tlast
);
  import njn_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item present after reset");

  // the last match is either still being produced or already in the output register
  a_probe_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready || m_tvalid)
    else $error("input taken before the last match of a probe");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:ROW_IDX_W+ROW_W] == '0)
    else $error("result pad bits not zero");

endmodule

bind nested_loop_equi_join_top njn_checker u_njn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
